// ===== design/bss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types for the bounded sequence store: operation codes, status codes
// and the result beat that travels from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package bss_pkg;

  typedef enum logic [2:0] {
    FN_PUSH    = 3'd0,
    FN_APPEND  = 3'd1,
    FN_INSERT  = 3'd2,
    FN_REMOVE  = 3'd3,
    FN_SORT_UP = 3'd4,
    FN_SORT_DN = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_READ    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [4:0]         entry_count;
    status_t            status;
    logic               last;
  } res_t;

endpackage

// ===== design/bss_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cmp
// Compare-swap unit of the bubble sort. The carried word is the larger (or
// smaller, descending) word of the pass so far; the other word settles at the
// lower index. Equal words never swap.
// ----------------------------------------------------------------------------
module bss_cmp (
  input  logic               descending,
  input  logic signed [31:0] carry,
  input  logic signed [31:0] incoming,
  output logic signed [31:0] low_word,
  output logic signed [31:0] carry_next
);

  logic swap;

  assign swap = descending ? (incoming > carry) : (carry > incoming);

  // On a swap the carried word moves on; otherwise it settles and the
  // incoming word is carried.
  assign low_word   = swap ? incoming : carry;
  assign carry_next = swap ? carry : incoming;

endmodule

// ===== design/bss_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_seq
// Sequencer and entry memory. Runs one operation at a time: element shifts
// for insert and remove, bubble passes through the shared compare-swap unit,
// and the read-out stream. Hands result beats to the output stage.
// ----------------------------------------------------------------------------
module bss_seq import bss_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         func,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               emit_valid,
  output res_t               emit,
  input  logic               take
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 5) ? CW : 5) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_WR,
    S_REM,
    S_REM_WR,
    S_SRT_FIRST,
    S_SRT_RUN,
    S_SRT_TAIL,
    S_RD_ADDR,
    S_RD_EMIT,
    S_RESP
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      ptr;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      pass;
  logic               desc;
  logic signed [31:0] val_r;
  logic signed [31:0] carry;
  status_t            st;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;

  func_t              fn;
  logic               full;
  logic               ins_bad;
  logic               rem_bad;
  logic [AW-1:0]      pos_idx;
  logic [AW-1:0]      ins_idx;
  logic               ptr_next_in;
  logic               more_passes;
  logic               sort_go;
  logic signed [31:0] low_word;
  logic signed [31:0] carry_next;

  assign fn          = func_t'(func);
  assign full        = (count == CW'(CAPACITY));
  assign ins_bad     = (position == 5'd0) || (XW'(position) > (XW'(count) + XW'(1)));
  assign rem_bad     = (position == 5'd0) || (XW'(position) > XW'(count));
  assign pos_idx     = AW'(XW'(position) - XW'(1));
  assign ptr_next_in = (CW'(ptr) + CW'(1)) < count;
  assign more_passes = (CW'(pass) + CW'(2)) < count;
  assign sort_go     = (fn == FN_SORT_UP || fn == FN_SORT_DN) && (count >= CW'(2));
  assign cmd_stall   = (state != S_IDLE);

  always_comb begin
    unique case (fn)
      FN_PUSH:   ins_idx = '0;
      FN_APPEND: ins_idx = AW'(count);
      default:   ins_idx = pos_idx;
    endcase
  end

  bss_cmp u_cmp (
    .descending (desc),
    .carry      (carry),
    .incoming   (rd_data),
    .low_word   (low_word),
    .carry_next (carry_next)
  );

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    mem_we  = 1'b0;
    mem_wa  = ptr;
    mem_wd  = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en = cmd_valid && sort_go;
      end
      S_INS: begin
        if (ptr == idx) begin
          mem_we = 1'b1;
          mem_wa = idx;
          mem_wd = val_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr - AW'(1);
        end
      end
      S_REM: begin
        rd_en   = ptr_next_in;
        rd_addr = ptr + AW'(1);
      end
      S_INS_WR, S_REM_WR: begin
        mem_we = 1'b1;
      end
      S_SRT_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      S_SRT_RUN: begin
        mem_we  = 1'b1;
        mem_wa  = ptr - AW'(1);
        mem_wd  = low_word;
        rd_en   = ptr_next_in;
        rd_addr = ptr + AW'(1);
      end
      S_SRT_TAIL: begin
        // Settle the carried word at the top and start the next pass, if one remains.
        mem_we = 1'b1;
        mem_wd = carry;
        rd_en  = more_passes;
      end
      S_RD_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = ptr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Result beat
  always_comb begin
    emit_valid       = 1'b0;
    emit.item_value  = '0;
    emit.entry_count = 5'(count);
    emit.status      = st;
    emit.last        = 1'b1;
    if (state == S_RESP) begin
      emit_valid = 1'b1;
    end else if (state == S_RD_EMIT) begin
      emit_valid      = 1'b1;
      emit.item_value = rd_data;
      emit.status     = ST_OK;
      emit.last       = !ptr_next_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            desc  <= (fn == FN_SORT_DN);
            val_r <= value;
            st    <= ST_OK;
            pass  <= '0;
            unique case (fn)
              FN_PUSH, FN_APPEND, FN_INSERT: begin
                ptr <= AW'(count);
                idx <= ins_idx;
                if (full) begin
                  st    <= ST_FULL;
                  state <= S_RESP;
                end else if (fn == FN_INSERT && ins_bad) begin
                  st    <= ST_BADPOS;
                  state <= S_RESP;
                end else begin
                  state <= S_INS;
                end
              end
              FN_REMOVE: begin
                ptr <= pos_idx;
                if (rem_bad) begin
                  st    <= ST_BADPOS;
                  state <= S_RESP;
                end else begin
                  state <= S_REM;
                end
              end
              FN_SORT_UP, FN_SORT_DN: begin
                state <= sort_go ? S_SRT_FIRST : S_RESP;
              end
              FN_CLEAR: begin
                count <= '0;
                state <= S_RESP;
              end
              FN_READ: begin
                ptr <= '0;
                if (count == '0) begin
                  st    <= ST_EMPTY;
                  state <= S_RESP;
                end else begin
                  state <= S_RD_ADDR;
                end
              end
            endcase
          end
        end
        S_INS: begin
          if (ptr == idx) begin
            count <= count + CW'(1);
            state <= S_RESP;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          ptr   <= ptr - AW'(1);
          state <= S_INS;
        end
        S_REM: begin
          if (ptr_next_in) begin
            state <= S_REM_WR;
          end else begin
            count <= count - CW'(1);
            state <= S_RESP;
          end
        end
        S_REM_WR: begin
          ptr   <= ptr + AW'(1);
          state <= S_REM;
        end
        S_SRT_FIRST: begin
          carry <= rd_data;
          ptr   <= AW'(1);
          state <= S_SRT_RUN;
        end
        S_SRT_RUN: begin
          carry <= carry_next;
          if (ptr_next_in) begin
            ptr <= ptr + AW'(1);
          end else begin
            state <= S_SRT_TAIL;
          end
        end
        S_SRT_TAIL: begin
          if (more_passes) begin
            pass  <= pass + AW'(1);
            state <= S_SRT_FIRST;
          end else begin
            state <= S_RESP;
          end
        end
        S_RD_ADDR: begin
          state <= S_RD_EMIT;
        end
        S_RD_EMIT: begin
          if (take) begin
            if (ptr_next_in) begin
              ptr   <= ptr + AW'(1);
              state <= S_RD_ADDR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid) |=> cmd_stall)
    else $error("command beat accepted without going busy");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (emit_valid && emit.status == ST_EMPTY) |-> (emit.entry_count == 5'd0 && emit.last))
    else $error("empty-store beat with entries or without last");

  a_sort_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRT_RUN) |-> (CW'(ptr) < count))
    else $error("sort pass index past the end");
`endif

endmodule

// ===== design/bounded_sequence_store_with_sort_unit.sv =====
`timescale 1ns / 1ps
// Steps: push/append/insert and remove shift entries via S_INS/S_INS_WR or S_REM/S_REM_WR,
//   then answer from S_RESP; clear and rejected commands go straight to S_RESP; a sort
//   pass makes one compare-swap per cycle; read-all alternates S_RD_ADDR and S_RD_EMIT.
// Throughput: one operation at a time through the shared compare-swap unit and the 1R1W
//   entry memory; the next command is taken once the last beat sits in the output register.
// Reset clears the entry count; entry contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// bounded_sequence_store_with_sort_unit
// Ordered store of up to CAPACITY signed words with insert, remove, bubble sort
// and in-order read-out. Result beats leave through a one-deep output register.
// ----------------------------------------------------------------------------
module bounded_sequence_store_with_sort_unit import bss_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         func,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] item_value,
  output logic [4:0]         entry_count,
  output logic [1:0]         status,
  output logic               last
);

  logic emit_valid;
  res_t emit;
  logic take;
  logic out_valid;
  res_t out_data;

  bss_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .func       (func),
    .position   (position),
    .value      (value),
    .emit_valid (emit_valid),
    .emit       (emit),
    .take       (take)
  );

  // Load a new beat whenever the register is empty or being drained.
  assign take = !out_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit_valid) begin
      out_data <= emit;
    end
  end

  assign rsp_valid   = out_valid;
  assign item_value  = out_data.item_value;
  assign entry_count = out_data.entry_count;
  assign status      = 2'(out_data.status);
  assign last        = out_data.last;

endmodule
